// File: sv/crl_pkg.sv
package crl_pkg;

  // Fixed widths of the word fields and state
  localparam int SampleW  = 16;
  localparam int PhaseW   = 24;
  localparam int IdxW     = 4;
  localparam int NumPts   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  // Operation codes of an input word
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PROC  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_PWR  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AGC_EN      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_AGC_ALPHA   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FREQ_GAIN   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PHASE_GAIN  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MAX_FREQ    = 3'd6;

  // Register reset values
  localparam logic [4:0]  RST_POINT_COUNT = 5'd4;
  localparam logic [30:0] RST_TARGET_PWR  = 31'd268435456;
  localparam logic [15:0] RST_AGC_ALPHA   = 16'd655;
  localparam logic [15:0] RST_FREQ_GAIN   = 16'd655;
  localparam logic [15:0] RST_PHASE_GAIN  = 16'd66;
  localparam logic [22:0] RST_MAX_FREQ    = 23'd1048576;
  localparam logic [31:0] RST_AGC_AVG     = 32'd268435456;

  // CORDIC constants: inverse gain in Q0.16 and a quarter turn
  localparam logic signed [16:0] InvGain = 17'sd39797;
  localparam logic signed [24:0] Quarter = 25'sd4194304;

  // Datapath step codes issued by the controller
  localparam logic [4:0] CMD_NONE     = 5'd0;
  localparam logic [4:0] CMD_AGC_SQ1  = 5'd1;
  localparam logic [4:0] CMD_AGC_SQ2  = 5'd2;
  localparam logic [4:0] CMD_AGC_M1   = 5'd3;
  localparam logic [4:0] CMD_AGC_M2   = 5'd4;
  localparam logic [4:0] CMD_DIV      = 5'd5;
  localparam logic [4:0] CMD_SQRT     = 5'd6;
  localparam logic [4:0] CMD_AGC_GI   = 5'd7;
  localparam logic [4:0] CMD_AGC_GQ   = 5'd8;
  localparam logic [4:0] CMD_ROT_INIT = 5'd9;
  localparam logic [4:0] CMD_ROT      = 5'd10;
  localparam logic [4:0] CMD_ROT_MUL  = 5'd11;
  localparam logic [4:0] CMD_ROT_RND  = 5'd12;
  localparam logic [4:0] CMD_SRCH_RD  = 5'd13;
  localparam logic [4:0] CMD_SRCH_CMP = 5'd14;
  localparam logic [4:0] CMD_DEC_RD   = 5'd15;
  localparam logic [4:0] CMD_DEC_M1   = 5'd16;
  localparam logic [4:0] CMD_DEC_M2   = 5'd17;
  localparam logic [4:0] CMD_DEC_M3   = 5'd18;
  localparam logic [4:0] CMD_VEC_INIT = 5'd19;
  localparam logic [4:0] CMD_VEC      = 5'd20;
  localparam logic [4:0] CMD_LOOP_M   = 5'd21;
  localparam logic [4:0] CMD_FIN      = 5'd22;

  typedef struct packed {
    logic       accept;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic agc_en;
    logic out_free;
  } stat_t;

  // CORDIC arctangent table in 2^-24 turn
  function automatic logic signed [24:0] crl_atan(input logic [3:0] k);
    logic signed [24:0] a;
    case (k)
      4'd0:    a = 25'sd2097152;
      4'd1:    a = 25'sd1238021;
      4'd2:    a = 25'sd654136;
      4'd3:    a = 25'sd332050;
      4'd4:    a = 25'sd166669;
      4'd5:    a = 25'sd83416;
      4'd6:    a = 25'sd41718;
      4'd7:    a = 25'sd20860;
      4'd8:    a = 25'sd10430;
      4'd9:    a = 25'sd5215;
      4'd10:   a = 25'sd2608;
      4'd11:   a = 25'sd1304;
      4'd12:   a = 25'sd652;
      4'd13:   a = 25'sd326;
      4'd14:   a = 25'sd163;
      default: a = 25'sd81;
    endcase
    return a;
  endfunction

  // Saturate a wide signed value to the sample range
  function automatic logic signed [15:0] crl_sat(input logic signed [49:0] v);
    logic signed [15:0] r;
    if (v > 50'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -50'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: sv/crl_ctrl.sv
module crl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       operation_i,
  input  crl_pkg::stat_t   stat_i,
  output crl_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_AGC_SQ1  = 5'd1;
  localparam logic [4:0] S_AGC_SQ2  = 5'd2;
  localparam logic [4:0] S_AGC_M1   = 5'd3;
  localparam logic [4:0] S_AGC_M2   = 5'd4;
  localparam logic [4:0] S_DIV      = 5'd5;
  localparam logic [4:0] S_SQRT     = 5'd6;
  localparam logic [4:0] S_AGC_GI   = 5'd7;
  localparam logic [4:0] S_AGC_GQ   = 5'd8;
  localparam logic [4:0] S_ROT_INIT = 5'd9;
  localparam logic [4:0] S_ROT      = 5'd10;
  localparam logic [4:0] S_ROT_MUL  = 5'd11;
  localparam logic [4:0] S_ROT_RND  = 5'd12;
  localparam logic [4:0] S_SRCH_RD  = 5'd13;
  localparam logic [4:0] S_SRCH_CMP = 5'd14;
  localparam logic [4:0] S_DEC_RD   = 5'd15;
  localparam logic [4:0] S_DEC_M1   = 5'd16;
  localparam logic [4:0] S_DEC_M2   = 5'd17;
  localparam logic [4:0] S_DEC_M3   = 5'd18;
  localparam logic [4:0] S_VEC_INIT = 5'd19;
  localparam logic [4:0] S_VEC      = 5'd20;
  localparam logic [4:0] S_LOOP_M   = 5'd21;
  localparam logic [4:0] S_FIN      = 5'd22;

  logic [4:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Next state and the step handed to the datapath
  always_comb begin
    state_d      = state_q;
    cmd_o.accept = accept;
    cmd_o.step   = crl_pkg::CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept && operation_i == crl_pkg::OP_PROC) begin
          state_d = stat_i.agc_en ? S_AGC_SQ1 : S_ROT_INIT;
        end
      end
      S_AGC_SQ1: begin
        cmd_o.step = crl_pkg::CMD_AGC_SQ1;
        state_d    = S_AGC_SQ2;
      end
      S_AGC_SQ2: begin
        cmd_o.step = crl_pkg::CMD_AGC_SQ2;
        state_d    = S_AGC_M1;
      end
      S_AGC_M1: begin
        cmd_o.step = crl_pkg::CMD_AGC_M1;
        state_d    = S_AGC_M2;
      end
      S_AGC_M2: begin
        cmd_o.step = crl_pkg::CMD_AGC_M2;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = crl_pkg::CMD_DIV;
        if (stat_i.last) state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.step = crl_pkg::CMD_SQRT;
        if (stat_i.last) state_d = S_AGC_GI;
      end
      S_AGC_GI: begin
        cmd_o.step = crl_pkg::CMD_AGC_GI;
        state_d    = S_AGC_GQ;
      end
      S_AGC_GQ: begin
        cmd_o.step = crl_pkg::CMD_AGC_GQ;
        state_d    = S_ROT_INIT;
      end
      S_ROT_INIT: begin
        cmd_o.step = crl_pkg::CMD_ROT_INIT;
        state_d    = S_ROT;
      end
      S_ROT: begin
        cmd_o.step = crl_pkg::CMD_ROT;
        if (stat_i.last) state_d = S_ROT_MUL;
      end
      S_ROT_MUL: begin
        cmd_o.step = crl_pkg::CMD_ROT_MUL;
        state_d    = S_ROT_RND;
      end
      S_ROT_RND: begin
        cmd_o.step = crl_pkg::CMD_ROT_RND;
        state_d    = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        cmd_o.step = crl_pkg::CMD_SRCH_RD;
        state_d    = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd_o.step = crl_pkg::CMD_SRCH_CMP;
        state_d    = stat_i.last ? S_DEC_RD : S_SRCH_RD;
      end
      S_DEC_RD: begin
        cmd_o.step = crl_pkg::CMD_DEC_RD;
        state_d    = S_DEC_M1;
      end
      S_DEC_M1: begin
        cmd_o.step = crl_pkg::CMD_DEC_M1;
        state_d    = S_DEC_M2;
      end
      S_DEC_M2: begin
        cmd_o.step = crl_pkg::CMD_DEC_M2;
        state_d    = S_DEC_M3;
      end
      S_DEC_M3: begin
        cmd_o.step = crl_pkg::CMD_DEC_M3;
        state_d    = S_VEC_INIT;
      end
      S_VEC_INIT: begin
        cmd_o.step = crl_pkg::CMD_VEC_INIT;
        state_d    = S_VEC;
      end
      S_VEC: begin
        cmd_o.step = crl_pkg::CMD_VEC;
        if (stat_i.last) state_d = S_LOOP_M;
      end
      S_LOOP_M: begin
        cmd_o.step = crl_pkg::CMD_LOOP_M;
        state_d    = S_FIN;
      end
      S_FIN: begin
        // Wait here while the previous result still sits in the output register
        if (stat_i.out_free) begin
          cmd_o.step = crl_pkg::CMD_FIN;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/crl_dp.sv
module crl_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  crl_pkg::cmd_t           cmd_i,
  output crl_pkg::stat_t          stat_o,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [30:0]             cfg_wdata_i,
  input  logic [1:0]              operation_i,
  input  logic [3:0]              point_index_i,
  input  logic signed [15:0]      sample_i_i,
  input  logic signed [15:0]      sample_q_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [15:0]      corrected_i_o,
  output logic signed [15:0]      corrected_q_o,
  output logic [3:0]              decision_index_o,
  output logic signed [23:0]      phase_error_o,
  output logic [31:0]             error_power_o
);

  // Configuration registers
  logic [4:0]  pc_q;
  logic [30:0] tp_q;
  logic        agc_en_q;
  logic [15:0] alpha_q, fg_q, pg_q;
  logic [22:0] lim_q;

  // Loop state
  logic [23:0]        phase_q;
  logic signed [23:0] freq_q;
  logic [31:0]        avg_q;

  // Constellation tables
  localparam int NumPtsL = crl_pkg::NumPts;
  logic signed [15:0] mem_i [NumPtsL];
  logic signed [15:0] mem_q [NumPtsL];
  logic signed [15:0] rd_i_q, rd_q_q;
  logic [3:0]         rd_addr;

  // Working registers
  logic [5:0]         iter_q;
  logic signed [15:0] wi_q, wq_q;
  logic [31:0]        psq_q, pw_q;
  logic [48:0]        m1_q;
  logic [62:0]        dq_q;
  logic [31:0]        rem_q;
  logic [63:0]        sv_q, sr_q, sb_q;
  logic signed [27:0] rx_q, ry_q;
  logic signed [24:0] rz_q;
  logic signed [44:0] pxk_q, pyk_q;
  logic signed [15:0] ci_q, cq_q;
  logic [3:0]         best_q;
  logic [34:0]        bd_q;
  logic signed [31:0] pa_q, pb_q;
  logic signed [32:0] re_q, im_q;
  logic signed [45:0] vx_q, vy_q;
  logic signed [24:0] vz_q;
  logic               vzero_q;
  logic signed [23:0] err_q;
  logic signed [40:0] prodf_q, prodp_q;

  // Output register
  logic               ov_q;
  logic signed [15:0] oi_q, oq_q;
  logic [3:0]         oidx_q;
  logic signed [23:0] oerr_q;
  logic [31:0]        opow_q;

  logic [4:0] step;
  logic [3:0] k;
  logic [3:0] nm1;
  logic       last;
  logic       iterative;

  assign step = cmd_i.step;
  assign k    = iter_q[3:0];

  // Last index searched, with the point count clamped to the table
  always_comb begin
    if (pc_q == 5'd0) begin
      nm1 = 4'd0;
    end else if (pc_q > 5'd16) begin
      nm1 = 4'd15;
    end else begin
      nm1 = 4'(pc_q - 5'd1);
    end
  end

  // End of each iterative step
  always_comb begin
    iterative = 1'b1;
    last      = 1'b0;
    case (step)
      crl_pkg::CMD_DIV:      last = (iter_q == 6'd62);
      crl_pkg::CMD_SQRT:     last = (iter_q == 6'd31);
      crl_pkg::CMD_ROT:      last = (iter_q == 6'd15);
      crl_pkg::CMD_VEC:      last = (iter_q == 6'd15);
      crl_pkg::CMD_SRCH_CMP: last = (k == nm1);
      default:               iterative = 1'b0;
    endcase
  end

  assign stat_o.last     = last;
  assign stat_o.agc_en   = agc_en_q;
  assign stat_o.out_free = ~ov_q | out_ready_i;

  // AGC arithmetic
  logic signed [15:0] sq_a;
  logic signed [31:0] sq_prod;
  logic [49:0]        avg_sum;
  logic [33:0]        avg_sh;
  logic [32:0]        trial;
  logic               ge;
  logic [63:0]        sq_t;
  logic [31:0]        gain;
  logic signed [15:0] g_a;
  logic signed [48:0] g_prod;
  logic signed [49:0] g_sum;

  assign sq_a    = (step == crl_pkg::CMD_AGC_SQ1) ? wi_q : wq_q;
  assign sq_prod = sq_a * sq_a;
  assign avg_sum = {1'b0, m1_q} + ({34'd0, alpha_q} * {18'd0, pw_q});
  assign avg_sh  = avg_sum[49:16];
  assign trial   = {rem_q, dq_q[62]};
  assign ge      = trial >= {1'b0, avg_q};
  assign sq_t    = sr_q + sb_q;
  assign gain    = (avg_q == 32'd0) ? 32'hFFFF_FFFF : sr_q[31:0];
  assign g_a     = (step == crl_pkg::CMD_AGC_GI) ? wi_q : wq_q;
  assign g_prod  = g_a * $signed({1'b0, gain});
  assign g_sum   = {g_prod[48], g_prod} + 50'sd32768;

  // NCO rotation arithmetic
  logic signed [16:0] ix, iy, qx, qy;
  logic signed [27:0] rdx, rdy;
  logic signed [24:0] atk;
  logic signed [49:0] rnd_x, rnd_y;

  assign ix    = {wi_q[15], wi_q};
  assign iy    = {wq_q[15], wq_q};
  assign rdx   = ry_q >>> k;
  assign rdy   = rx_q >>> k;
  assign atk   = crl_pkg::crl_atan(k);
  assign rnd_x = {{5{pxk_q[44]}}, pxk_q} + 50'sd8388608;
  assign rnd_y = {{5{pyk_q[44]}}, pyk_q} + 50'sd8388608;

  always_comb begin
    case (phase_q[23:22])
      2'd1: begin
        qx = -iy;
        qy = ix;
      end
      2'd2: begin
        qx = -ix;
        qy = -iy;
      end
      2'd3: begin
        qx = iy;
        qy = -ix;
      end
      default: begin
        qx = ix;
        qy = iy;
      end
    endcase
  end

  // Distance to a table point
  logic signed [16:0] ei, eq;
  logic signed [33:0] sqi, sqq;
  logic [34:0]        pt_dist;

  assign ei      = {ci_q[15], ci_q} - {rd_i_q[15], rd_i_q};
  assign eq      = {cq_q[15], cq_q} - {rd_q_q[15], rd_q_q};
  assign sqi     = ei * ei;
  assign sqq     = eq * eq;
  assign pt_dist = {1'b0, sqi} + {1'b0, sqq};

  // Detector vectoring arithmetic
  logic signed [37:0] ex, ey, vx0, vy0;
  logic signed [24:0] vz0;
  logic signed [45:0] vdx, vdy;
  logic signed [24:0] negz;
  logic signed [23:0] err_w;

  assign ex   = 38'(re_q);
  assign ey   = 38'(im_q);
  assign vdx  = vy_q >>> k;
  assign vdy  = vx_q >>> k;
  assign negz = -vz_q;
  assign err_w = vzero_q ? 24'sd0 : negz[23:0];

  always_comb begin
    vx0 = ex;
    vy0 = ey;
    vz0 = 25'sd0;
    if (ex < 0) begin
      if (ey >= 0) begin
        vx0 = ey;
        vy0 = -ex;
        vz0 = crl_pkg::Quarter;
      end else begin
        vx0 = -ey;
        vy0 = ex;
        vz0 = -crl_pkg::Quarter;
      end
    end
  end

  // Loop filter update
  logic signed [40:0] fsum, psum;
  logic signed [25:0] nf, lims;
  logic signed [23:0] fnew;

  assign fsum = prodf_q + 41'sd32768;
  assign psum = prodp_q + 41'sd32768;
  assign nf   = {{2{freq_q[23]}}, freq_q} + {fsum[40], fsum[40:16]};
  assign lims = {3'b000, lim_q};
  assign fnew = (nf > lims || nf < -lims) ? 24'sd0 : nf[23:0];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= crl_pkg::RST_POINT_COUNT;
      tp_q     <= crl_pkg::RST_TARGET_PWR;
      agc_en_q <= 1'b0;
      alpha_q  <= crl_pkg::RST_AGC_ALPHA;
      fg_q     <= crl_pkg::RST_FREQ_GAIN;
      pg_q     <= crl_pkg::RST_PHASE_GAIN;
      lim_q    <= crl_pkg::RST_MAX_FREQ;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        crl_pkg::REG_POINT_COUNT: pc_q     <= cfg_wdata_i[4:0];
        crl_pkg::REG_TARGET_PWR:  tp_q     <= cfg_wdata_i;
        crl_pkg::REG_AGC_EN:      agc_en_q <= cfg_wdata_i[0];
        crl_pkg::REG_AGC_ALPHA:   alpha_q  <= cfg_wdata_i[15:0];
        crl_pkg::REG_FREQ_GAIN:   fg_q     <= cfg_wdata_i[15:0];
        crl_pkg::REG_PHASE_GAIN:  pg_q     <= cfg_wdata_i[15:0];
        crl_pkg::REG_MAX_FREQ:    lim_q    <= cfg_wdata_i[22:0];
        default: ;
      endcase
    end
  end

  // Table memory: write on a load word, registered read
  assign rd_addr = (step == crl_pkg::CMD_DEC_RD) ? best_q : k;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && operation_i == crl_pkg::OP_LOAD) begin
      mem_i[point_index_i] <= sample_i_i;
      mem_q[point_index_i] <= sample_q_i;
    end
    if (step == crl_pkg::CMD_SRCH_RD || step == crl_pkg::CMD_DEC_RD) begin
      rd_i_q <= mem_i[rd_addr];
      rd_q_q <= mem_q[rd_addr];
    end
  end

  // Loop state and iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      freq_q  <= '0;
      avg_q   <= crl_pkg::RST_AGC_AVG;
      iter_q  <= '0;
    end else begin
      if (iterative) begin
        iter_q <= last ? 6'd0 : iter_q + 6'd1;
      end else if (step != crl_pkg::CMD_SRCH_RD) begin
        iter_q <= '0;
      end
      if (cmd_i.accept && operation_i == crl_pkg::OP_CLEAR) begin
        phase_q <= '0;
        freq_q  <= '0;
        avg_q   <= {1'b0, tp_q};
      end
      if (step == crl_pkg::CMD_AGC_M2) begin
        avg_q <= (avg_sh[33:32] != 2'b00) ? 32'hFFFF_FFFF : avg_sh[31:0];
      end
      if (step == crl_pkg::CMD_FIN) begin
        freq_q  <= fnew;
        phase_q <= phase_q + fnew + psum[39:16];
      end
    end
  end

  // Datapath steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      wi_q <= sample_i_i;
      wq_q <= sample_q_i;
    end
    case (step)
      crl_pkg::CMD_AGC_SQ1: psq_q <= sq_prod;
      crl_pkg::CMD_AGC_SQ2: pw_q  <= psq_q + sq_prod;
      crl_pkg::CMD_AGC_M1:  m1_q  <= (17'h10000 - {1'b0, alpha_q}) * avg_q;
      crl_pkg::CMD_AGC_M2: begin
        dq_q  <= {tp_q, 32'd0};
        rem_q <= '0;
      end
      crl_pkg::CMD_DIV: begin
        rem_q <= ge ? 32'(trial - {1'b0, avg_q}) : trial[31:0];
        dq_q  <= {dq_q[61:0], ge};
        if (last) begin
          sv_q <= {1'b0, dq_q[61:0], ge};
          sr_q <= '0;
          sb_q <= 64'h4000_0000_0000_0000;
        end
      end
      crl_pkg::CMD_SQRT: begin
        if (sv_q >= sq_t) begin
          sv_q <= sv_q - sq_t;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      crl_pkg::CMD_AGC_GI: wi_q <= crl_pkg::crl_sat(g_sum >>> 16);
      crl_pkg::CMD_AGC_GQ: wq_q <= crl_pkg::crl_sat(g_sum >>> 16);
      crl_pkg::CMD_ROT_INIT: begin
        rx_q <= {{3{qx[16]}}, qx, 8'd0};
        ry_q <= {{3{qy[16]}}, qy, 8'd0};
        rz_q <= {3'b000, phase_q[21:0]};
      end
      crl_pkg::CMD_ROT: begin
        if (!rz_q[24]) begin
          rx_q <= rx_q - rdx;
          ry_q <= ry_q + rdy;
          rz_q <= rz_q - atk;
        end else begin
          rx_q <= rx_q + rdx;
          ry_q <= ry_q - rdy;
          rz_q <= rz_q + atk;
        end
      end
      crl_pkg::CMD_ROT_MUL: begin
        pxk_q <= rx_q * crl_pkg::InvGain;
        pyk_q <= ry_q * crl_pkg::InvGain;
      end
      crl_pkg::CMD_ROT_RND: begin
        ci_q <= crl_pkg::crl_sat(rnd_x >>> 24);
        cq_q <= crl_pkg::crl_sat(rnd_y >>> 24);
      end
      crl_pkg::CMD_SRCH_CMP: begin
        if (k == 4'd0 || pt_dist < bd_q) begin
          bd_q   <= pt_dist;
          best_q <= k;
        end
      end
      crl_pkg::CMD_DEC_M1: begin
        pa_q <= ci_q * rd_i_q;
        pb_q <= cq_q * rd_q_q;
      end
      crl_pkg::CMD_DEC_M2: begin
        re_q <= {pa_q[31], pa_q} + {pb_q[31], pb_q};
        pa_q <= cq_q * rd_i_q;
        pb_q <= ci_q * rd_q_q;
      end
      crl_pkg::CMD_DEC_M3: im_q <= {pa_q[31], pa_q} - {pb_q[31], pb_q};
      crl_pkg::CMD_VEC_INIT: begin
        vzero_q <= (re_q == 33'sd0) && (im_q == 33'sd0);
        vx_q    <= {vx0, 8'd0};
        vy_q    <= {vy0, 8'd0};
        vz_q    <= vz0;
      end
      crl_pkg::CMD_VEC: begin
        if (!vy_q[45]) begin
          vx_q <= vx_q + vdx;
          vy_q <= vy_q - vdy;
          vz_q <= vz_q + atk;
        end else begin
          vx_q <= vx_q - vdx;
          vy_q <= vy_q + vdy;
          vz_q <= vz_q - atk;
        end
      end
      crl_pkg::CMD_LOOP_M: begin
        err_q   <= err_w;
        prodf_q <= $signed({1'b0, fg_q}) * err_w;
        prodp_q <= $signed({1'b0, pg_q}) * err_w;
      end
      crl_pkg::CMD_FIN: begin
        oi_q   <= ci_q;
        oq_q   <= cq_q;
        oidx_q <= best_q;
        oerr_q <= err_q;
        opow_q <= (bd_q[34:32] != 3'b000) ? 32'hFFFF_FFFF : bd_q[31:0];
      end
      default: ;
    endcase
  end

  // Result word valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (step == crl_pkg::CMD_FIN) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  assign out_valid_o      = ov_q;
  assign corrected_i_o    = oi_q;
  assign corrected_q_o    = oq_q;
  assign decision_index_o = oidx_q;
  assign phase_error_o    = oerr_q;
  assign error_power_o    = opow_q;

endmodule

// File: sv/agc_carrier_recovery_loop_unit.sv
// Decision-directed carrier recovery with optional AGC. Load words (operation 0) and clear
// words (operation 2) give no result. A sample word (operation 1) is worked on alone by
// a sequencer over a shared datapath; the AGC adds the 63-step restoring divider and the
// 32-step square root. The 16-step rotation CORDIC, the table search, which reads and
// compares the N points searched in turn through the registered table read port, and the
// 16-step vectoring CORDIC make up the rest of the work. A result waits in an output
// register, and the next word is taken while it does.
module agc_carrier_recovery_loop_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         point_index_i,
  input  logic signed [15:0] sample_i_i,
  input  logic signed [15:0] sample_q_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] corrected_i_o,
  output logic signed [15:0] corrected_q_o,
  output logic [3:0]         decision_index_o,
  output logic signed [23:0] phase_error_o,
  output logic [31:0]        error_power_o
);

  crl_pkg::cmd_t  cmd;
  crl_pkg::stat_t stat;

  crl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  crl_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .operation_i      (operation_i),
    .point_index_i    (point_index_i),
    .sample_i_i       (sample_i_i),
    .sample_q_i       (sample_q_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .corrected_i_o    (corrected_i_o),
    .corrected_q_o    (corrected_q_o),
    .decision_index_o (decision_index_o),
    .phase_error_o    (phase_error_o),
    .error_power_o    (error_power_o)
  );

endmodule

// File: sv/crl_chk.sv
module crl_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         operation_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] corrected_i_o,
  input logic signed [23:0] phase_error_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(corrected_i_o)
      && $stable(phase_error_o))
    else $error("result word changed while stalled");

  // A sample word keeps the block busy for the next cycle
  a_proc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == crl_pkg::OP_PROC |=> !in_ready_o)
    else $error("input taken while a sample is being worked on");

  // Words other than sample words leave the block ready again in the next cycle
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i != crl_pkg::OP_PROC |=> in_ready_o)
    else $error("load or clear word held the block busy");

  // A new result appears just as the block turns idle again
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while the block is still busy");

endmodule

bind agc_carrier_recovery_loop_unit crl_chk u_crl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .corrected_i_o (corrected_i_o),
  .phase_error_o (phase_error_o)
);
